### hdl/tmtw_pkg.sv
// Shared types and constants for the text mode terminal writer.
// Holds the payload structs, the controller/datapath link structs and fixed widths.
// No dependencies.
package tmtw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Fixed field widths.
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int ADDR_W   = 11;
  localparam int CHAR_W   = 8;
  localparam int NUM_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W    = 4 * NUM_DIGITS;
  localparam int BITCNT_W = 5;
  localparam int DIGCNT_W = 4;

  // Character and attribute codes.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0]        RESET_COLOR  = 8'd7;

  // Command codes.
  localparam logic CMD_CHAR   = 1'b0;
  localparam logic CMD_NUMBER = 1'b1;

  // One input item.
  typedef struct packed {
    logic                    command;
    logic [CHAR_W-1:0]       char_code;
    logic signed [NUM_W-1:0] number;
  } in_item_t;

  // One buffer write.
  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [15:0]       write_entry;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic newline;
    logic conv_step;
    logic trim_shift;
    logic emit_char;
    logic emit_digit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_number;
    logic is_newline;
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic slot_free;
  } dp_status_t;

endpackage

### hdl/text_mode_terminal_writer_top.sv
// Text mode terminal writer: top level.
// Usage:
//   The input channel (in_valid/in_ready/in_item) takes one command per transfer:
//   a character, or a signed 32-bit number printed in decimal without a sign.
//   The result channel (out_valid/out_ready/out_item) carries buffer writes:
//   cell address row*COLUMNS+column and an entry of attribute and character.
//   The last write caused by a command has last set; a newline causes none.
//   cfg_we/cfg_wdata write the attribute byte; write it only while idle.
// Sequencing:
//   One command is handled at a time, and no new command is taken until the
//   last write of the current one is in the output register. A character is
//   written once the output register is free. A number is loaded at its
//   transfer, then goes through the shift-and-add-3 binary to decimal loop, a
//   step that drops each leading zero, and the digit writes, each of which
//   waits while the output register is full and out_ready is low.
// Reset: rst_n is synchronous, active low; cursor goes to row 0, column 0,
//   the attribute byte to 7 and the output register empties.
// Stall: a write waits in the output register while out_ready is low, and the
//   next digit or character write holds until that register drains.
// Depends on tmtw_pkg, tmtw_ctrl and tmtw_dp.
module text_mode_terminal_writer_top #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmtw_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tmtw_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import tmtw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Cursor, converter and output register.
  tmtw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### hdl/tmtw_ctrl.sv
// Controller state machine for the text mode terminal writer.
// Sequences item acceptance, binary to decimal conversion, digit trimming and emission.
// Depends on tmtw_pkg.
module tmtw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmtw_pkg::dp_status_t status,
  output tmtw_pkg::ctrl_cmd_t  cmd
);
  import tmtw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHAR = 5'b00010,
    S_CONV = 5'b00100,
    S_TRIM = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (status.is_number) begin
            state_nxt = S_CONV;
          end else if (status.is_newline) begin
            cmd.newline = 1'b1;
          end else begin
            state_nxt = S_CHAR;
          end
        end
      end
      S_CHAR: begin
        if (status.slot_free) begin
          cmd.emit_char = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_done) begin
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        if (status.top_zero && !status.one_left) begin
          cmd.trim_shift = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (status.one_left) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/tmtw_dp.sv
// Datapath for the text mode terminal writer.
// Holds the cursor, attribute register, decimal converter and output register.
// Depends on tmtw_pkg.
module tmtw_dp #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmtw_pkg::in_item_t   in_item,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  tmtw_pkg::ctrl_cmd_t  cmd,
  output tmtw_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tmtw_pkg::out_item_t  out_item
);
  import tmtw_pkg::*;

  // Apply the add-3 correction to every decimal digit that is five or more.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [7:0]          color_r;
  logic [CHAR_W-1:0]   char_r;
  logic [NUM_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BITCNT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [DIGCNT_W-1:0] digleft_r, digleft_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic [NUM_W-1:0]    magnitude;
  logic [BCD_W-1:0]    bcd_adj;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [ROW_W-1:0]    row_adv;
  logic [ADDR_W:0]     addr_full;
  logic [CHAR_W-1:0]   emit_code;
  logic                emit;

  // Input decode and magnitude of the signed number.
  assign magnitude = in_item.number[NUM_W-1] ? (~in_item.number + 32'd1) : in_item.number;

  assign status.is_number  = (in_item.command == CMD_NUMBER);
  assign status.is_newline = (in_item.char_code == NEWLINE_CODE);
  assign status.conv_done  = (bitcnt_r == BITCNT_W'(NUM_W - 1));
  assign status.top_zero   = (bcd_r[BCD_W-1 -: 4] == 4'd0);
  assign status.one_left   = (digleft_r == DIGCNT_W'(1));
  assign status.slot_free  = !out_valid_r || out_ready;

  // Cursor arithmetic and cell address.
  assign col_inc   = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc   = {1'b0, row_r} + (ROW_W+1)'(1);
  assign row_adv   = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
  assign addr_full = (ADDR_W+1)'(row_r) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(col_r);
  assign emit      = cmd.emit_char || cmd.emit_digit;
  assign emit_code = cmd.emit_char ? char_r : (DIGIT_ZERO + {4'd0, bcd_r[BCD_W-1 -: 4]});
  assign bcd_adj   = bcd_adjust(bcd_r);

  // Next-state logic for cursor, converter and output register.
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    bitcnt_nxt    = bitcnt_r;
    digleft_nxt   = digleft_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    // Cursor moves on a newline or after each write.
    if (cmd.newline) begin
      col_nxt = '0;
      row_nxt = row_adv;
    end else if (emit) begin
      if (col_inc >= (COL_W+1)'(COLUMNS)) begin
        col_nxt = '0;
        row_nxt = row_adv;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end

    // Converter: load, shift-and-adjust steps, then digit shifts.
    priority if (cmd.load) begin
      bin_nxt     = magnitude;
      bcd_nxt     = '0;
      bitcnt_nxt  = '0;
      digleft_nxt = DIGCNT_W'(NUM_DIGITS);
    end else if (cmd.conv_step) begin
      bcd_nxt    = {bcd_adj[BCD_W-2:0], bin_r[NUM_W-1]};
      bin_nxt    = {bin_r[NUM_W-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r + BITCNT_W'(1);
    end else if (cmd.trim_shift || cmd.emit_digit) begin
      bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
      digleft_nxt = digleft_r - DIGCNT_W'(1);
    end else begin
    end

    // Output register: load on a write, drain on a transfer.
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.write_address = addr_full[ADDR_W-1:0];
      out_item_nxt.write_entry   = {color_r, emit_code};
      out_item_nxt.last          = cmd.emit_char || status.one_left;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_item.char_code;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    bitcnt_r   <= bitcnt_nxt;
    digleft_r  <= digleft_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hdl/tmtw_checker.sv
// Port-level checks for the text mode terminal writer.
// Holds the checker module and the bind that attaches it to the top level.
// Depends on tmtw_pkg and text_mode_terminal_writer_top.
module tmtw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tmtw_pkg::out_item_t out_item
);
  import tmtw_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled write stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("write dropped while stalled");

  // A stalled write keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("write payload changed while stalled");

  // While a number is still being written, no new command is taken.
  a_busy_in_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> !in_ready)
    else $error("input taken in the middle of a number");

  // Any write that is not the last one is a decimal digit.
  a_digit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |->
      (out_item.write_entry[7:0] >= DIGIT_ZERO) &&
      (out_item.write_entry[7:0] <= DIGIT_ZERO + 8'd9))
    else $error("non-final write is not a digit");

endmodule

bind text_mode_terminal_writer_top tmtw_checker u_tmtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### tb/tb_top.sv
// Self-checking testbench for text_mode_terminal_writer_top: drives characters and numbers,
// predicts every buffer write from its own cursor and attribute state, and compares them.
// Depends on tmtw_pkg and the text_mode_terminal_writer_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  localparam int IDLE_SETTLE = 8;
  localparam int MAX_REPORTS = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  // Predicted screen state.
  logic [COL_W-1:0] col_model   = '0;
  logic [ROW_W-1:0] row_model   = '0;
  logic [7:0]       color_model = RESET_COLOR;

  // Buffer writes predicted but not yet seen on the result channel.
  out_item_t pending_writes[$];
  out_item_t want_write;

  int  mismatch_count = 0;
  int  ready_hold     = 0;
  bit  no_idle        = 1'b0;

  text_mode_terminal_writer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Run time limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Place one character at the predicted cursor and advance it with wrapping.
  task automatic place_cell(input logic [CHAR_W-1:0] code, input logic is_last);
    out_item_t w;
    int        cell_idx;
    cell_idx        = int'(row_model) * DEF_COLUMNS + int'(col_model);
    w.write_address = cell_idx[ADDR_W-1:0];
    w.write_entry   = {color_model, code};
    w.last          = is_last;
    pending_writes.push_back(w);
    if (int'(col_model) + 1 >= DEF_COLUMNS) begin
      col_model = '0;
      if (int'(row_model) + 1 >= DEF_ROWS) row_model = '0;
      else row_model = row_model + ROW_W'(1);
    end else begin
      col_model = col_model + COL_W'(1);
    end
  endtask

  // Work out the writes that one accepted command causes.
  task automatic predict_console_writes(input in_item_t item);
    logic [NUM_W-1:0] mag;
    logic [3:0]       digits[NUM_DIGITS];
    int               n;
    if (item.command == CMD_CHAR) begin
      if (item.char_code == NEWLINE_CODE) begin
        col_model = '0;
        if (int'(row_model) + 1 >= DEF_ROWS) row_model = '0;
        else row_model = row_model + ROW_W'(1);
      end else begin
        place_cell(item.char_code, 1'b1);
      end
    end else begin
      // Only the magnitude is printed; the most negative value wraps to 2^31.
      mag = item.number[NUM_W-1] ? (~item.number + 32'd1) : item.number;
      n = 0;
      do begin
        digits[n] = 4'(mag % 10);
        mag       = mag / 10;
        n++;
      end while (mag != 0 && n < NUM_DIGITS);
      for (int k = 0; k < n; k++)
        place_cell(DIGIT_ZERO + 8'(digits[n - 1 - k]), k == n - 1);
    end
  endtask

  // Send one command and predict its writes once in_ready is sampled high.
  task automatic send_command(input in_item_t item);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    predict_console_writes(item);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] code);
    in_item_t item;
    item.command   = CMD_CHAR;
    item.char_code = code;
    item.number    = $urandom;
    send_command(item);
  endtask

  task automatic send_number(input logic signed [NUM_W-1:0] value);
    in_item_t item;
    item.command   = CMD_NUMBER;
    item.char_code = 8'($urandom_range(0, 255));
    item.number    = value;
    send_command(item);
  endtask

  // Stop sending and wait until every predicted write has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    color_model = value;
  endtask

  function automatic logic signed [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic signed [NUM_W-1:0] ten_digit_number();
    return 32'd1000000000 + $urandom_range(0, 1147483647);
  endfunction

  task automatic go_to_last_row();
    while (int'(row_model) != DEF_ROWS - 1) send_char(NEWLINE_CODE);
  endtask

  // Characters under the reset attribute, with the character code extremes.
  task automatic test_single_characters();
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(NEWLINE_CODE);
    send_char(8'h20);
  endtask

  // Numbers: zero, sign handling, digit count extremes.
  task automatic test_decimal_numbers();
    send_number(32'sd0);
    send_number(32'sd1);
    send_number(-32'sd1);
    send_number(32'sd9);
    send_number(32'sd10);
    send_number(32'sd2147483647);
    send_number(32'h8000_0000);
    send_number(-32'sd1000000000);
    send_number(32'sd999999999);
    send_number(32'sd123456789);
    send_char(NEWLINE_CODE);
  endtask

  // Attribute byte at its extremes and a mixed value.
  task automatic test_color_register();
    write_color(8'h00);
    send_char(8'h58);
    send_number(-32'sd42);
    write_color(8'hFF);
    send_char(8'h59);
    send_number(32'sd7);
    write_color(8'hA5);
    send_char(8'h5A);
  endtask

  // Column wrap inside a number on the last row, then row wrap by newline.
  task automatic test_cursor_wrap();
    send_char(NEWLINE_CODE);
    go_to_last_row();
    send_char(8'h23);
    repeat (8) send_number(ten_digit_number());
    send_char(8'h24);
    go_to_last_row();
    send_char(8'h25);
    send_char(NEWLINE_CODE);
    send_char(8'h26);
  endtask

  // Random mix of characters, newlines and numbers.
  task automatic test_random_traffic(input int count, input bit busy);
    int pick;
    no_idle = busy;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_char(8'($urandom_range(32, 126)));
      else if (pick < 55) send_char(8'($urandom_range(0, 255)));
      else if (pick < 65) send_char(NEWLINE_CODE);
      else if (pick < 70) send_number(pick[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      else send_number(random_number());
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Result side stall: a fresh hold-off after every transfer.
  always @(posedge clk) begin
    if (out_valid && out_ready) ready_hold = draw_wait();
    else if (ready_hold > 0) ready_hold--;
    out_ready <= (ready_hold == 0);
  end

  // Compare each write transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_error($sformatf("unexpected write: addr %0d entry %h last %b",
                               out_item.write_address, out_item.write_entry, out_item.last));
      end else begin
        want_write = pending_writes.pop_front();
        if (out_item.write_address !== want_write.write_address)
          report_error($sformatf("write_address: expected %0d, got %0d",
                                 want_write.write_address, out_item.write_address));
        if (out_item.write_entry !== want_write.write_entry)
          report_error($sformatf("write_entry: expected %h, got %h",
                                 want_write.write_entry, out_item.write_entry));
        if (out_item.last !== want_write.last)
          report_error($sformatf("last: expected %b, got %b",
                                 want_write.last, out_item.last));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_characters();
    test_decimal_numbers();
    test_color_register();
    test_cursor_wrap();
    write_color(8'h07);
    test_random_traffic(30, 1'b0);
    write_color(8'h00);
    test_random_traffic(30, 1'b1);
    write_color(8'($urandom_range(0, 255)));
    test_random_traffic(30, 1'b0);
    write_color(8'hFF);
    test_random_traffic(30, 1'b0);
    write_color(8'($urandom_range(0, 255)));
    test_random_traffic(30, 1'b0);
    wait_idle();
    repeat (50) @(posedge clk);
    if (pending_writes.size() != 0)
      report_error($sformatf("%0d predicted writes never arrived", pending_writes.size()));
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hdl/tmtw_pkg.sv
hdl/tmtw_ctrl.sv
hdl/tmtw_dp.sv
hdl/text_mode_terminal_writer_top.sv
hdl/tmtw_checker.sv
tb/tb_top.sv
